@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the blur RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define GB3_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("gb3 check failed");

// When pre holds, post must hold at the same edge.
`define GB3_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gb3 check failed");

`endif

@@ hw/rtl/gb3_pkg.sv @@
// Shared types and constants of the 3x3 gaussian blur.
package gb3_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int GEOM_W      = 13;
  localparam int CHAN_W      = 3;
  localparam int WEIGHT_W    = 16;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EDGE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CORNER = 3'd6;

  // Classification of one item, decided in the front end
  typedef struct packed {
    logic emit;
    logic row_last;
    logic frame_last;
  } gb3_tag_t;

  // Geometry after clamping to the supported range
  typedef struct packed {
    logic [GEOM_W-1:0] width;
    logic [GEOM_W-1:0] height;
    logic [CHAN_W-1:0] channels;
  } gb3_geom_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] max_value;
    logic [WEIGHT_W-1:0] w_center;
    logic [WEIGHT_W-1:0] w_edge;
    logic [WEIGHT_W-1:0] w_corner;
  } gb3_kernel_t;

endpackage

@@ hw/rtl/gaussian_blur_3x3.sv @@
// Top level of the streaming 3x3 gaussian blur with configuration registers.
//
// Usage:
//  - in_* channel: one sample of the border-padded raster per item, row-major,
//    channels interleaved. in_frame_start marks the first sample of a frame and
//    puts the position back to row 0, column 0.
//  - out_* channel: one item per interior sample, the blurred value clamped to
//    max_value, with row_last / frame_last on the last sample of a row / frame.
//    Padding samples produce no output item.
//  - cfg_*: register i is written at an edge with cfg_we high; write only while
//    no item is in flight.
//  - Throughput is one item per clock in both directions while out_ready is high.
//    The accepting edge loads the first front-end stage; the item then passes the
//    second position/divide stage, the queue, the registered line buffer read, the
//    sum and multiply stages and the output register, which drives out_valid.
//  - When out_ready is low with out_valid high, the back end holds; the front end
//    takes items until the four-entry queue is committed, then in_ready drops.
//  - Reset clears position, windows and queue and loads the register defaults.
//    The line buffer memory is not cleared; the padding rows fill it before use.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH            = 4096,
  parameter int MAX_CHANNELS         = 4,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gb3_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gb3_pkg::SAMPLE_W-1:0]    out_pixel_out,
  output logic                            out_row_last,
  output logic                            out_frame_last,
  input  logic                            cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gb3_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 2) * MAX_CHANNELS;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int Q_W        = COL_W + CH_W + SAMPLE_W + $bits(gb3_tag_t);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [GEOM_W-1:0]   image_width_r, image_height_r;
  logic [CHAN_W-1:0]   channel_count_r;
  logic [SAMPLE_W-1:0] max_value_r;
  logic [WEIGHT_W-1:0] weight_center_r, weight_edge_r, weight_corner_r;

  gb3_geom_t   geom;
  gb3_kernel_t kernel;

  logic                in_fire;
  logic                push_valid;
  logic [SAMPLE_W-1:0] push_sample;
  logic [COL_W-1:0]    push_col;
  logic [CH_W-1:0]     push_ch;
  gb3_tag_t            push_tag;
  logic [1:0]          inflight;

  logic [Q_W-1:0]      q_out;
  logic                q_not_empty, q_pop;
  logic [CNT_W-1:0]    q_count;
  logic [SAMPLE_W-1:0] q_sample;
  logic [COL_W-1:0]    q_col;
  logic [CH_W-1:0]     q_ch;
  gb3_tag_t            q_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= GEOM_W'(640);
      image_height_r  <= GEOM_W'(480);
      channel_count_r <= CHAN_W'(3);
      max_value_r     <= SAMPLE_W'(255);
      weight_center_r <= WEIGHT_W'(16384);
      weight_edge_r   <= WEIGHT_W'(8192);
      weight_corner_r <= WEIGHT_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data[GEOM_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[GEOM_W-1:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHAN_W-1:0];
        CFG_MAX_VALUE:     max_value_r     <= cfg_data[SAMPLE_W-1:0];
        CFG_WEIGHT_CENTER: weight_center_r <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_EDGE:   weight_edge_r   <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_CORNER: weight_corner_r <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range geometry: zero acts as one, oversize acts as the limit.
  always_comb begin
    if (image_width_r == '0) begin
      geom.width = GEOM_W'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      geom.width = GEOM_W'(MAX_WIDTH);
    end else begin
      geom.width = image_width_r;
    end
    if (image_height_r == '0) begin
      geom.height = GEOM_W'(1);
    end else if (int'(image_height_r) > HEIGHT_LIMIT) begin
      geom.height = GEOM_W'(HEIGHT_LIMIT);
    end else begin
      geom.height = image_height_r;
    end
    if (channel_count_r == '0) begin
      geom.channels = CHAN_W'(1);
    end else if (int'(channel_count_r) > MAX_CHANNELS) begin
      geom.channels = CHAN_W'(MAX_CHANNELS);
    end else begin
      geom.channels = channel_count_r;
    end
  end

  assign kernel.max_value = max_value_r;
  assign kernel.w_center  = weight_center_r;
  assign kernel.w_edge    = weight_edge_r;
  assign kernel.w_corner  = weight_corner_r;

  // The front end never stalls, so an item is only taken when the queue has a
  // place reserved for it and for everything already in the front pipeline.
  assign in_ready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(inflight)) < (CNT_W+1)'(QUEUE_DEPTH);
  assign in_fire  = in_valid && in_ready;

  gb3_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .geom           (geom),
    .push_valid     (push_valid),
    .push_sample    (push_sample),
    .push_col       (push_col),
    .push_ch        (push_ch),
    .push_tag       (push_tag),
    .inflight       (inflight)
  );

  gb3_queue #(
    .DEPTH (QUEUE_DEPTH),
    .W     (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_col, push_ch, push_sample, push_tag}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign {q_col, q_ch, q_sample, q_tag} = q_out;

  gb3_back #(
    .MAX_WIDTH            (MAX_WIDTH),
    .MAX_CHANNELS         (MAX_CHANNELS),
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_sample       (q_sample),
    .q_col          (q_col),
    .q_ch           (q_ch),
    .q_tag          (q_tag),
    .q_pop          (q_pop),
    .kernel         (kernel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last)
  );

endmodule

@@ hw/rtl/gb3_front.sv @@
// Front end: raster position tracking and classification of each item.
`include "assert_macros.svh"

module gb3_front #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_fire,
  input  logic [gb3_pkg::SAMPLE_W-1:0]                     in_sample,
  input  logic                                             in_frame_start,
  input  gb3_pkg::gb3_geom_t                               geom,
  output logic                                             push_valid,
  output logic [gb3_pkg::SAMPLE_W-1:0]                     push_sample,
  output logic [$clog2((MAX_WIDTH+2)*MAX_CHANNELS)-1:0]    push_col,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] push_ch,
  output gb3_pkg::gb3_tag_t                                push_tag,
  output logic [1:0]                                       inflight
);
  import gb3_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 2) * MAX_CHANNELS;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int RL_W       = $clog2(LINE_DEPTH + 1);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W      = GEOM_W;
  localparam int RLF_W      = GEOM_W + 1 + CHAN_W;
  localparam int XW         = (COL_W > GEOM_W + 1) ? COL_W : GEOM_W + 1;
  // divide by three as multiply by a rounded-up reciprocal; exact for col < 2^COL_W
  localparam int RECIP_SH   = COL_W + 2;
  localparam int RECIP_W    = RECIP_SH - 1;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
  localparam int PROD_W     = COL_W + RECIP_W;

  // position state
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [RLF_W-1:0] row_len_full;
  logic [RL_W-1:0]  row_len;
  logic             col_wrap, row_wrap;

  // stage a: position known
  logic                a_v_r;
  logic [SAMPLE_W-1:0] a_sample_r;
  logic [COL_W-1:0]    a_col_r;
  logic [ROW_W-1:0]    a_row_r;
  logic [PROD_W-1:0]   prod3;
  logic [COL_W-1:0]    x3, x_a;

  // stage b: pixel column known
  logic                b_v_r;
  logic [SAMPLE_W-1:0] b_sample_r;
  logic [COL_W-1:0]    b_col_r;
  logic [ROW_W-1:0]    b_row_r;
  logic [COL_W-1:0]    b_x_r;
  logic [COL_W-1:0]    xc, ch_full;
  logic                emit, row_end;

  assign row_len_full = (RLF_W'(geom.width) + RLF_W'(2)) * RLF_W'(geom.channels);
  assign row_len      = RL_W'(row_len_full);

  assign col_cur  = in_frame_start ? '0 : col_r;
  assign row_cur  = in_frame_start ? '0 : row_r;
  assign col_wrap = ((RL_W+1)'(col_cur) + (RL_W+1)'(1)) >= (RL_W+1)'(row_len);
  assign row_wrap = ((ROW_W+1)'(row_cur) + (ROW_W+1)'(1)) >=
                    ((ROW_W+1)'(geom.height) + (ROW_W+1)'(2));
  assign col_nxt  = col_wrap ? '0 : col_cur + COL_W'(1);
  assign row_nxt  = !col_wrap ? row_cur : (row_wrap ? '0 : row_cur + ROW_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      a_v_r <= in_fire;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_sample_r <= in_sample;
    a_col_r    <= col_cur;
    a_row_r    <= row_cur;
    b_sample_r <= a_sample_r;
    b_col_r    <= a_col_r;
    b_row_r    <= a_row_r;
    b_x_r      <= x_a;
  end

  // pixel column = col / channels
  assign prod3 = PROD_W'(a_col_r) * PROD_W'(RECIP3);
  assign x3    = COL_W'(prod3 >> RECIP_SH);

  always_comb begin
    unique case (geom.channels)
      3'd1:    x_a = a_col_r;
      3'd2:    x_a = a_col_r >> 1;
      3'd3:    x_a = x3;
      default: x_a = a_col_r >> 2;
    endcase
  end

  // channel = col - x * channels
  always_comb begin
    unique case (geom.channels)
      3'd1:    xc = b_x_r;
      3'd2:    xc = b_x_r << 1;
      3'd3:    xc = (b_x_r << 1) + b_x_r;
      default: xc = b_x_r << 2;
    endcase
  end
  assign ch_full = b_col_r - xc;

  assign emit = (b_row_r >= ROW_W'(2)) &&
                ((ROW_W+1)'(b_row_r) <= (ROW_W+1)'(geom.height) + (ROW_W+1)'(1)) &&
                (b_x_r >= COL_W'(2)) &&
                (XW'(b_x_r) <= XW'(geom.width) + XW'(1)) &&
                (RL_W'(b_col_r) < row_len);
  assign row_end = (XW'(b_x_r) == XW'(geom.width) + XW'(1)) &&
                   (ch_full == COL_W'(geom.channels) - COL_W'(1));

  assign push_valid          = b_v_r;
  assign push_sample         = b_sample_r;
  assign push_col            = b_col_r;
  assign push_ch             = CH_W'(ch_full);
  assign push_tag.emit       = emit;
  assign push_tag.row_last   = row_end;
  assign push_tag.frame_last = row_end &&
                               ((ROW_W+1)'(b_row_r) == (ROW_W+1)'(geom.height) + (ROW_W+1)'(1));
  assign inflight            = {1'b0, a_v_r} + {1'b0, b_v_r};

  `GB3_ASSERT_IMP(a_chan_in_range, b_v_r, ch_full < COL_W'(geom.channels))

endmodule

@@ hw/rtl/gb3_queue.sv @@
// Short FIFO decoupling the classifying front end from the filter back end.
`include "assert_macros.svh"

module gb3_queue #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic [W-1:0]               pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  `GB3_ASSERT_IMP(a_no_overflow, push && !pop, count_r < CNT_W'(DEPTH))
  `GB3_ASSERT_IMP(a_no_underflow, pop, count_r != '0)

endmodule

@@ hw/rtl/gb3_back.sv @@
// Back end: line buffer memory, per-channel 3x3 windows, weighted sum and output register.
`include "assert_macros.svh"

module gb3_back #(
  parameter int MAX_WIDTH            = 4096,
  parameter int MAX_CHANNELS         = 4,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             q_valid,
  input  logic [gb3_pkg::SAMPLE_W-1:0]                     q_sample,
  input  logic [$clog2((MAX_WIDTH+2)*MAX_CHANNELS)-1:0]    q_col,
  input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] q_ch,
  input  gb3_pkg::gb3_tag_t                                q_tag,
  output logic                                             q_pop,
  input  gb3_pkg::gb3_kernel_t                             kernel,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic [gb3_pkg::SAMPLE_W-1:0]                     out_pixel_out,
  output logic                                             out_row_last,
  output logic                                             out_frame_last
);
  import gb3_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 2) * MAX_CHANNELS;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W      = SAMPLE_W + 2;
  localparam int PROD_W     = SUM_W + WEIGHT_W;
  localparam int ACC_W      = PROD_W + 2;

  logic adv;

  // line buffers: upper byte is the row two back, lower byte the row one back
  logic [2*SAMPLE_W-1:0] line_mem [LINE_DEPTH];
  logic [2*SAMPLE_W-1:0] rd_r;
  logic [2*SAMPLE_W-1:0] fwd_d_r;
  logic                  fwd_r;

  // B1: memory data returned
  logic                v1_r;
  logic [SAMPLE_W-1:0] s1_r;
  logic [COL_W-1:0]    col1_r;
  logic [CH_W-1:0]     ch1_r;
  gb3_tag_t            tag1_r;
  logic [SAMPLE_W-1:0] up, mid;

  logic [SAMPLE_W-1:0] win_r [MAX_CHANNELS][9];
  logic [SAMPLE_W-1:0] nt [9];

  // B2: neighborhood sums
  logic                v2_r, rl2_r, fl2_r;
  logic [SUM_W-1:0]    corner2_r, edge2_r;
  logic [SAMPLE_W-1:0] center2_r;

  // B3: weighted terms
  logic                v3_r, rl3_r, fl3_r;
  logic [PROD_W-1:0]   pc3_r, pe3_r, pm3_r;

  logic [ACC_W-1:0]    acc, scaled;
  logic [SAMPLE_W-1:0] clamped;

  logic                out_valid_r, out_row_last_r, out_frame_last_r;
  logic [SAMPLE_W-1:0] out_pixel_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  // back-to-back items at the same address see the write still in flight
  assign up  = fwd_r ? fwd_d_r[2*SAMPLE_W-1:SAMPLE_W] : rd_r[2*SAMPLE_W-1:SAMPLE_W];
  assign mid = fwd_r ? fwd_d_r[SAMPLE_W-1:0]          : rd_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) rd_r <= line_mem[q_col];
    if (adv && v1_r) line_mem[col1_r] <= {mid, s1_r};
  end

  always_comb begin
    nt[0] = win_r[ch1_r][1];
    nt[1] = win_r[ch1_r][2];
    nt[2] = up;
    nt[3] = win_r[ch1_r][4];
    nt[4] = win_r[ch1_r][5];
    nt[5] = mid;
    nt[6] = win_r[ch1_r][7];
    nt[7] = win_r[ch1_r][8];
    nt[8] = s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        for (int k = 0; k < 9; k++) begin
          win_r[i][k] <= '0;
        end
      end
    end else if (adv) begin
      v1_r  <= q_pop;
      fwd_r <= q_pop && v1_r && (col1_r == q_col);
      v2_r  <= v1_r && tag1_r.emit;
      v3_r  <= v2_r;
      if (v1_r) begin
        for (int k = 0; k < 9; k++) begin
          win_r[ch1_r][k] <= nt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= q_sample;
      col1_r    <= q_col;
      ch1_r     <= q_ch;
      tag1_r    <= q_tag;
      fwd_d_r   <= {mid, s1_r};
      corner2_r <= SUM_W'(nt[0]) + SUM_W'(nt[2]) + SUM_W'(nt[6]) + SUM_W'(nt[8]);
      edge2_r   <= SUM_W'(nt[1]) + SUM_W'(nt[3]) + SUM_W'(nt[5]) + SUM_W'(nt[7]);
      center2_r <= nt[4];
      rl2_r     <= tag1_r.row_last;
      fl2_r     <= tag1_r.frame_last;
      pc3_r     <= PROD_W'(corner2_r) * PROD_W'(kernel.w_corner);
      pe3_r     <= PROD_W'(edge2_r) * PROD_W'(kernel.w_edge);
      pm3_r     <= PROD_W'(center2_r) * PROD_W'(kernel.w_center);
      rl3_r     <= rl2_r;
      fl3_r     <= fl2_r;
    end
  end

  assign acc     = ACC_W'(pc3_r) + ACC_W'(pe3_r) + ACC_W'(pm3_r);
  assign scaled  = acc >> WEIGHT_FRACTION_BITS;
  assign clamped = (scaled > ACC_W'(kernel.max_value)) ? kernel.max_value
                                                       : SAMPLE_W'(scaled);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3_r) begin
      out_pixel_r      <= clamped;
      out_row_last_r   <= rl3_r;
      out_frame_last_r <= fl3_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_row_last   = out_row_last_r;
  assign out_frame_last = out_frame_last_r;

  `GB3_ASSERT_IMP(a_fwd_has_item, fwd_r, v1_r)
  `GB3_ASSERT_IMP(a_frame_end_is_row_end, out_valid_r && out_frame_last_r, out_row_last_r)

endmodule

@@ tb/gaussian_blur_3x3_tb.sv @@
// Self-checking testbench for gaussian_blur_3x3: random raster stream against a bit-true predictor.
module gaussian_blur_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  // DUT build, kept equal to the predictor's view
  localparam int MAX_W      = 4096;
  localparam int MAX_CH     = 4;
  localparam int FRAC_BITS  = 16;
  localparam int LINE_DEPTH = (MAX_W + 2) * MAX_CH;

  // Pause after the last result before touching registers
  localparam int DRAIN_CYCLES = 20;
  // Receiver back-pressure burst, long enough to fill the 4-entry queue and the pipe
  localparam int HOLD_CYCLES  = 200;
  // Cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                fs;
  } raster_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic                row_last;
    logic                frame_last;
  } blur_px_t;

  typedef enum {PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_RAILS} pattern_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_pixel_out;
  logic                  out_row_last;
  logic                  out_frame_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_blur_3x3 #(
    .MAX_WIDTH            (MAX_W),
    .MAX_CHANNELS         (MAX_CH),
    .WEIGHT_FRACTION_BITS (FRAC_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies (reset defaults), line buffers, per-channel
  // 3x3 windows and the raster position. Line buffers start at zero; entries
  // are only ever consumed in rows >= 2 after the padding rows wrote them.
  // ---------------------------------------------------------------------------
  logic [GEOM_W-1:0]   blur_width  = 13'd640;
  logic [GEOM_W-1:0]   blur_height = 13'd480;
  logic [CHAN_W-1:0]   blur_chans  = 3'd3;
  logic [SAMPLE_W-1:0] blur_max    = 8'd255;
  logic [WEIGHT_W-1:0] wt_center   = 16'd16384;
  logic [WEIGHT_W-1:0] wt_edge     = 16'd8192;
  logic [WEIGHT_W-1:0] wt_corner   = 16'd4096;

  bit [SAMPLE_W-1:0] upper_line [LINE_DEPTH];
  bit [SAMPLE_W-1:0] lower_line [LINE_DEPTH];
  bit [SAMPLE_W-1:0] taps [MAX_CH][9];
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  raster_item_t raster_q[$];     // items waiting for the driver
  blur_px_t     expected_px[$];  // blurred samples not yet seen on out_*

  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned random_items   = 0;
  int unsigned results_seen   = 0;
  int unsigned hold_left      = 0;
  int unsigned fail_count     = 0;
  bit          steady         = 1'b0;  // both sides stop idling while set
  raster_item_t next_item;
  blur_px_t     want;

  // Register values as the block uses them: zero and oversize get clamped
  function automatic void blur_geometry(output int unsigned w, h, c);
    w = (blur_width == 0) ? 1 : (blur_width > MAX_W) ? MAX_W : blur_width;
    h = (blur_height == 0) ? 1 : (blur_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : blur_height;
    c = (blur_chans == 0) ? 1 : (blur_chans > MAX_CH) ? MAX_CH : blur_chans;
  endfunction

  // One accepted raster sample: update buffers/window, queue a result if interior
  task automatic convolve_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
    int unsigned     w, h, c, row_len, col, row, ch, x, k;
    bit [7:0]        up, mid;
    longint unsigned corners, sides, acc, v;
    blur_px_t        px;
    blur_geometry(w, h, c);
    row_len = (w + 2) * c;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    ch  = col % c;
    x   = col / c;
    // The two buffers act as a two-row shift register per column
    if (col < LINE_DEPTH) begin
      up  = upper_line[col];
      mid = lower_line[col];
      upper_line[col] = mid;
      lower_line[col] = s;
    end else begin
      up  = '0;
      mid = '0;
    end
    for (k = 0; k < 3; k++) begin
      taps[ch][k*3]   = taps[ch][k*3+1];
      taps[ch][k*3+1] = taps[ch][k*3+2];
    end
    taps[ch][2] = up;
    taps[ch][5] = mid;
    taps[ch][8] = s;
    // Window is centered one row up and one pixel back from the incoming sample
    if (row >= 2 && row <= h + 1 && x >= 2 && x <= w + 1 && col < row_len) begin
      corners = taps[ch][0] + taps[ch][2] + taps[ch][6] + taps[ch][8];
      sides   = taps[ch][1] + taps[ch][3] + taps[ch][5] + taps[ch][7];
      acc     = corners * wt_corner + sides * wt_edge + taps[ch][4] * wt_center;
      v       = acc >> FRAC_BITS;
      if (v > blur_max) v = blur_max;
      px.pixel      = v[7:0];
      px.row_last   = (x == w + 1) && (ch == c - 1);
      px.frame_last = px.row_last && (row == h + 1);
      expected_px.push_back(px);
    end
    // A position past a shrunken row wraps here without producing anything
    if (col + 1 >= row_len) begin
      col_pos = 0;
      row_pos = (row + 1 >= h + 2) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes items from raster_q, predicts each one as it is accepted.
  // in_valid gets at most one NBA per edge, so back-to-back items never glitch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_sample      <= '0;
      in_frame_start <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        convolve_sample(in_sample, in_frame_start);
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (raster_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          next_item = raster_q.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= next_item.sample;
          in_frame_start <= next_item.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: in-order compare against the oldest prediction. Two long ready
  // holds are counted here so the front-end queue fills and in_ready drops.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          $error("unexpected item: pixel_out %0d row_last %0b frame_last %0b",
                 out_pixel_out, out_row_last, out_frame_last);
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
            fail_count++;
          end
          if (out_row_last !== want.row_last) begin
            $error("row_last: expected %0b, got %0b", want.row_last, out_row_last);
            fail_count++;
          end
          if (out_frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, out_frame_last);
            fail_count++;
          end
        end
        if (results_seen == 100 || results_seen == 400) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  // Hang detection: any handshake restarts the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One register write; the predictor copy changes at the same edge as the DUT
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:   blur_width  = data[GEOM_W-1:0];
      CFG_IMAGE_HEIGHT:  blur_height = data[GEOM_W-1:0];
      CFG_CHANNEL_COUNT: blur_chans  = data[CHAN_W-1:0];
      CFG_MAX_VALUE:     blur_max    = data[SAMPLE_W-1:0];
      CFG_WEIGHT_CENTER: wt_center   = data[WEIGHT_W-1:0];
      CFG_WEIGHT_EDGE:   wt_edge     = data[WEIGHT_W-1:0];
      CFG_WEIGHT_CORNER: wt_corner   = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Raw 16-bit values: bits above a register's width are noise the block drops
  task automatic program_regs(input logic [15:0] width_raw, height_raw, chans_raw, max_raw,
                              center_raw, side_raw, corner_raw);
    write_reg(CFG_IMAGE_WIDTH, width_raw);
    write_reg(CFG_IMAGE_HEIGHT, height_raw);
    write_reg(CFG_CHANNEL_COUNT, chans_raw);
    write_reg(CFG_MAX_VALUE, max_raw);
    write_reg(CFG_WEIGHT_CENTER, center_raw);
    write_reg(CFG_WEIGHT_EDGE, side_raw);
    write_reg(CFG_WEIGHT_CORNER, corner_raw);
    cfg_we <= 1'b0;
  endtask

  // Queue a padded frame for the current geometry; count != 0 cuts or stretches it.
  // A noisy frame gets stray frame_start marks that restart the position.
  task automatic push_frame(input pattern_t pat, input bit restart, input bit noisy,
                            input int unsigned count);
    int unsigned  w, h, c, total, n;
    raster_item_t it;
    blur_geometry(w, h, c);
    total = (count != 0) ? count : (w + 2) * c * (h + 2);
    for (n = 0; n < total; n++) begin
      case (pat)
        PAT_ZERO:  it.sample = 8'h00;
        PAT_FULL:  it.sample = 8'hFF;
        PAT_RAILS: it.sample = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        default:   it.sample = 8'($urandom);
      endcase
      it.fs = (n == 0) ? restart : (noisy && $urandom_range(99) < 2);
      raster_q.push_back(it);
    end
    queued_items += total;
  endtask

  // Sender holds until every item is in and every result is out, then lets
  // the tail of the pipe settle (items past the last result may still be inside)
  task automatic drain();
    while (accepted_items != queued_items || expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(12000));
    endcase
  endfunction

  function automatic logic [15:0] pick_max();
    logic [7:0] m;
    case ($urandom_range(5))
      0:       m = 8'd0;   // clamps everything to zero
      1:       m = 8'd1;
      2:       m = 8'd255;
      default: m = 8'($urandom_range(255, 1));
    endcase
    return {8'($urandom), m};
  endfunction

  // Random geometry and kernel, then one to three frames. Most frames are
  // clean; some are cut short, continue without a restart, or carry stray
  // frame_start marks.
  task automatic random_phase();
    logic [15:0] wr, hr, cr;
    int unsigned roll, wsel, hsel, w, h, c, total, frames, f, cut, start_count;
    pattern_t    pat;
    start_count = queued_items;
    roll = $urandom_range(99);
    wsel = (roll < 75) ? $urandom_range(5) :
           (roll < 95) ? $urandom_range(16, 6) : $urandom_range(40, 17);
    hsel = ($urandom_range(99) < 80) ? $urandom_range(4) : $urandom_range(10, 5);
    wr = {3'($urandom), 13'(wsel)};
    hr = {3'($urandom), 13'(hsel)};
    cr = {13'($urandom), 3'($urandom_range(7))};
    program_regs(wr, hr, cr, pick_max(), pick_weight(), pick_weight(), pick_weight());
    blur_geometry(w, h, c);
    total  = (w + 2) * c * (h + 2);
    frames = $urandom_range(3, 1);
    for (f = 0; f < frames; f++) begin
      pat = pattern_t'($urandom_range(3));
      cut = ($urandom_range(99) < 15) ? $urandom_range(total - 1, 1) : 0;
      // first frame after a register change always restarts the position
      push_frame(pat, (f == 0) || ($urandom_range(3) != 0), $urandom_range(99) < 10, cut);
    end
    drain();
    random_items += queued_items - start_count;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame, all-white: unity kernel gives 255 exactly
    program_regs(16'd1, 16'd1, 16'd1, 16'd255, 16'd16384, 16'd8192, 16'd4096);
    push_frame(PAT_FULL, 1'b1, 1'b0, 0);
    drain();

    // Zero geometry reads as 1x1x1; max_value 0 forces a zero output even
    // with full-scale weights. High data bits are set and must be ignored.
    program_regs(16'hE000, 16'h6000, 16'hFFF8, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_frame(PAT_FULL, 1'b1, 1'b0, 0);
    drain();

    while (random_items < 350) random_phase();

    // Shrink mid-frame: stop at row 3, column 25 of an 8x4x3 frame, then drop
    // to 2x1x1 and keep streaming without a restart. The stale position sits
    // past the new row and must wrap silently.
    program_regs(16'd8, 16'd4, 16'd3, 16'd255, 16'd20000, 16'd9000, 16'd3000);
    push_frame(PAT_RANDOM, 1'b1, 1'b0, 0);
    push_frame(PAT_RANDOM, 1'b1, 1'b0, 3 * 30 + 25);
    drain();
    program_regs(16'd2, 16'd1, 16'd1, 16'd200, 16'd30000, 16'd7000, 16'd2500);
    push_frame(PAT_RANDOM, 1'b0, 1'b0, 40);
    drain();

    while (random_items < 850) random_phase();

    // Long stretch at full rate on both sides: one 16x8x3 frame, no idling
    steady = 1'b1;
    program_regs(16'd16, 16'd8, 16'd3, 16'd255, 16'd16384, 16'd8192, 16'd4096);
    push_frame(PAT_RANDOM, 1'b1, 1'b0, 0);
    drain();
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
